[design/assert_macros.svh]
// assertion macros used by greedy_box_nms_unit
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GBN_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GBN_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define GBN_ASSERT(lbl, clk, rst_n, prop, msg)
`define GBN_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

[design/gbn_pkg.sv]
// shared types and constants for the greedy box nms unit
// no dependencies
package gbn_pkg;

    localparam logic [15:0] THR_RESET = 16'd32768;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_AREA,
        ST_RUN,
        ST_FIN
    } gbn_state_t;

    // control part of the token walking down the cell chain
    typedef struct packed {
        logic valid;
        logic supp;
        logic chk;
    } tok_ctl_t;

endpackage

[design/gbn_in_if.sv]
// input channel of the greedy box nms unit: one candidate box per beat
// no dependencies
interface gbn_in_if;
    logic        valid;
    logic        ready;
    logic        first_of_set;
    logic [15:0] x_left;
    logic [15:0] y_top;
    logic [15:0] x_right;
    logic [15:0] y_bottom;
    logic [7:0]  class_id;
    logic [15:0] confidence;

    modport source (output valid, first_of_set, x_left, y_top, x_right, y_bottom,
                    class_id, confidence, input ready);
    modport sink (input valid, first_of_set, x_left, y_top, x_right, y_bottom,
                  class_id, confidence, output ready);
endinterface

[design/gbn_out_if.sv]
// output channel of the greedy box nms unit: one kept box per beat
// no dependencies
interface gbn_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_x_left;
    logic [15:0] out_y_top;
    logic [15:0] out_x_right;
    logic [15:0] out_y_bottom;
    logic [7:0]  out_class;
    logic [15:0] out_confidence;
    logic        store_overflow;

    modport source (output valid, out_x_left, out_y_top, out_x_right, out_y_bottom,
                    out_class, out_confidence, store_overflow, input ready);
    modport sink (input valid, out_x_left, out_y_top, out_x_right, out_y_bottom,
                  out_class, out_confidence, store_overflow, output ready);
endinterface

[design/gbn_cell.sv]
// one kept-box slot of the suppression chain: holds a box and its area,
// checks the passing candidate against it; uses gbn_pkg
module gbn_cell #(
    parameter int IDX = 0,
    parameter int C   = 16,
    parameter int CW  = 7,
    parameter int IW  = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  gbn_pkg::tok_ctl_t     ctl_in,
    input  logic [C-1:0]          xl_in,
    input  logic [C-1:0]          yt_in,
    input  logic [C-1:0]          xr_in,
    input  logic [C-1:0]          yb_in,
    input  logic [2*C-1:0]        area_in,
    input  logic [2*C-1:0]        inter_in,
    input  logic [2*C:0]          uni_in,
    input  logic [15:0]           thr,
    input  logic [CW-1:0]         count,
    input  logic                  wr_en,
    input  logic [IW-1:0]         wr_idx,
    output gbn_pkg::tok_ctl_t     ctl_out,
    output logic [C-1:0]          xl_out,
    output logic [C-1:0]          yt_out,
    output logic [C-1:0]          xr_out,
    output logic [C-1:0]          yb_out,
    output logic [2*C-1:0]        area_out,
    output logic [2*C-1:0]        inter_out,
    output logic [2*C:0]          uni_out
);
    import gbn_pkg::*;

    localparam int AW = 2 * C;
    localparam int UW = 2 * C + 1;
    localparam logic [CW-1:0] IDX_C = CW'(IDX);
    localparam logic [IW-1:0] IDX_W = IW'(IDX);

    logic [C-1:0]  kxl_reg, kyt_reg, kxr_reg, kyb_reg;
    logic [AW-1:0] karea_reg;

    tok_ctl_t      ctl_reg, ctl_next;
    logic [C-1:0]  xl_reg, yt_reg, xr_reg, yb_reg;
    logic [AW-1:0] area_reg, inter_reg, inter_next;
    logic [UW-1:0] uni_reg, uni_next;

    logic [C-1:0]  lo_x, hi_x, lo_y, hi_y, ix, iy;
    logic [UW-1:0] sum;
    logic [UW+15:0] lhs, rhs;

    always_comb
    begin
        lo_x = (xl_in > kxl_reg) ? xl_in : kxl_reg;
        hi_x = (xr_in < kxr_reg) ? xr_in : kxr_reg;
        lo_y = (yt_in > kyt_reg) ? yt_in : kyt_reg;
        hi_y = (yb_in < kyb_reg) ? yb_in : kyb_reg;
        ix = (hi_x > lo_x) ? hi_x - lo_x : '0;
        iy = (hi_y > lo_y) ? hi_y - lo_y : '0;
        inter_next = AW'(ix) * AW'(iy);
        sum = UW'(area_in) + UW'(karea_reg);
        uni_next = (sum > UW'(inter_next)) ? sum - UW'(inter_next) : '0;
        // finish the check left pending by the previous cell
        lhs = {1'b0, inter_in, 16'h0000};
        rhs = (UW + 16)'(uni_in) * (UW + 16)'(thr);
        ctl_next.valid = ctl_in.valid;
        ctl_next.supp = ctl_in.supp | (ctl_in.chk & (lhs > rhs));
        ctl_next.chk = ctl_in.valid & (IDX_C < count) & (uni_next != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xl_reg <= xl_in;
        yt_reg <= yt_in;
        xr_reg <= xr_in;
        yb_reg <= yb_in;
        area_reg <= area_in;
        inter_reg <= inter_next;
        uni_reg <= uni_next;
        if (wr_en && (wr_idx == IDX_W))
        begin
            kxl_reg <= xl_in;
            kyt_reg <= yt_in;
            kxr_reg <= xr_in;
            kyb_reg <= yb_in;
            karea_reg <= area_in;
        end
    end

    assign ctl_out = ctl_reg;
    assign xl_out = xl_reg;
    assign yt_out = yt_reg;
    assign xr_out = xr_reg;
    assign yb_out = yb_reg;
    assign area_out = area_reg;
    assign inter_out = inter_reg;
    assign uni_out = uni_reg;

endmodule

[design/greedy_box_nms_unit.sv]
// greedy box nms unit: one candidate at a time walks a chain of MAX_KEPT cells
// a box passes the area step, the chain and then the decision step, where a kept box
// waits for room in the output register; only then is a new box taken
// a new box is taken while the previous result still waits in the output register
// reset clears the kept count, the state and sets the threshold to 0.5; stored boxes
// are not cleared, entries at or above the count are never looked at
module greedy_box_nms_unit #(
    parameter int MAX_KEPT   = 64,
    parameter int COORD_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    gbn_in_if.sink      in_ch,
    gbn_out_if.source   out_ch
);
    import gbn_pkg::*;
    `include "assert_macros.svh"

    localparam int C  = COORD_BITS;
    localparam int N  = MAX_KEPT;
    localparam int AW = 2 * C;
    localparam int UW = 2 * C + 1;
    localparam int CW = $clog2(N + 1);
    localparam int IW = (N > 1) ? $clog2(N) : 1;
    localparam logic [CW-1:0] FULL = CW'(N);

    function automatic logic [C-1:0] to_coord(input logic [15:0] v);
        logic [39:0] w;
        w = 40'(v);
        return w[C-1:0];
    endfunction

    gbn_state_t    state_reg, state_next;
    logic [15:0]   thr_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [C-1:0]  cxl_reg, cyt_reg, cxr_reg, cyb_reg;
    logic [7:0]    class_reg;
    logic [15:0]   conf_reg;
    logic          fsupp_reg;

    tok_ctl_t      tok0_ctl_reg, tok0_ctl_next;
    logic [AW-1:0] tok0_area_reg;

    logic          ov_reg;
    logic          ov_reg_next;
    logic          out_valid_reg;
    logic [15:0]   oxl_reg, oyt_reg, oxr_reg, oyb_reg, oconf_reg;
    logic [7:0]    oclass_reg;

    logic          accept, out_free, load_out, store_wr;
    logic [C-1:0]  ex, ey;
    logic [AW-1:0] area_w;
    logic [UW+15:0] lhs, rhs;

    tok_ctl_t      t_ctl   [0:N];
    logic [C-1:0]  t_xl    [0:N];
    logic [C-1:0]  t_yt    [0:N];
    logic [C-1:0]  t_xr    [0:N];
    logic [C-1:0]  t_yb    [0:N];
    logic [AW-1:0] t_area  [0:N];
    logic [AW-1:0] t_inter [0:N];
    logic [UW-1:0] t_uni   [0:N];

    assign accept = in_ch.valid & in_ch.ready;
    assign out_free = ~out_valid_reg | out_ch.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_AREA;
            ST_AREA: state_next = ST_RUN;
            ST_RUN:  if (t_ctl[N].valid) state_next = ST_FIN;
            ST_FIN:  if (fsupp_reg || out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the control
    always_comb
    begin
        in_ch.ready = 1'b0;
        load_out = 1'b0;
        store_wr = 1'b0;
        unique case (state_reg)
            ST_IDLE: in_ch.ready = 1'b1;
            ST_FIN:
            begin
                load_out = ~fsupp_reg & out_free;
                store_wr = ~fsupp_reg & out_free & (cnt_reg < FULL);
            end
            default: ;
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept && in_ch.first_of_set)
        begin
            cnt_next = '0;
        end
        else if (store_wr)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        ov_reg_next = (cnt_reg == FULL);
    end

    always_comb
    begin
        ex = (cxr_reg > cxl_reg) ? cxr_reg - cxl_reg : '0;
        ey = (cyb_reg > cyt_reg) ? cyb_reg - cyt_reg : '0;
        area_w = AW'(ex) * AW'(ey);
        tok0_ctl_next.valid = (state_reg == ST_AREA);
        tok0_ctl_next.supp = 1'b0;
        tok0_ctl_next.chk = 1'b0;
        // pending check of the last cell
        lhs = {1'b0, t_inter[N], 16'h0000};
        rhs = (UW + 16)'(t_uni[N]) * (UW + 16)'(thr_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            thr_reg <= THR_RESET;
            cnt_reg <= '0;
            tok0_ctl_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
            cnt_reg <= cnt_next;
            tok0_ctl_reg <= tok0_ctl_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cxl_reg <= to_coord(in_ch.x_left);
            cyt_reg <= to_coord(in_ch.y_top);
            cxr_reg <= to_coord(in_ch.x_right);
            cyb_reg <= to_coord(in_ch.y_bottom);
            class_reg <= in_ch.class_id;
            conf_reg <= in_ch.confidence;
        end
        if (state_reg == ST_AREA)
        begin
            tok0_area_reg <= area_w;
        end
        if (t_ctl[N].valid)
        begin
            fsupp_reg <= t_ctl[N].supp | (t_ctl[N].chk & (lhs > rhs));
        end
        if (load_out)
        begin
            oxl_reg <= 16'(cxl_reg);
            oyt_reg <= 16'(cyt_reg);
            oxr_reg <= 16'(cxr_reg);
            oyb_reg <= 16'(cyb_reg);
            oclass_reg <= class_reg;
            oconf_reg <= conf_reg;
            ov_reg <= ov_reg_next;
        end
    end

    assign t_ctl[0] = tok0_ctl_reg;
    assign t_xl[0] = cxl_reg;
    assign t_yt[0] = cyt_reg;
    assign t_xr[0] = cxr_reg;
    assign t_yb[0] = cyb_reg;
    assign t_area[0] = tok0_area_reg;
    assign t_inter[0] = '0;
    assign t_uni[0] = '0;

    for (genvar j = 0; j < N; j++)
    begin : g_cell
        gbn_cell #(
            .IDX (j),
            .C   (C),
            .CW  (CW),
            .IW  (IW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl_in    (t_ctl[j]),
            .xl_in     (t_xl[j]),
            .yt_in     (t_yt[j]),
            .xr_in     (t_xr[j]),
            .yb_in     (t_yb[j]),
            .area_in   (t_area[j]),
            .inter_in  (t_inter[j]),
            .uni_in    (t_uni[j]),
            .thr       (thr_reg),
            .count     (cnt_reg),
            .wr_en     (store_wr),
            .wr_idx    (cnt_reg[IW-1:0]),
            .ctl_out   (t_ctl[j+1]),
            .xl_out    (t_xl[j+1]),
            .yt_out    (t_yt[j+1]),
            .xr_out    (t_xr[j+1]),
            .yb_out    (t_yb[j+1]),
            .area_out  (t_area[j+1]),
            .inter_out (t_inter[j+1]),
            .uni_out   (t_uni[j+1])
        );
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.out_x_left = oxl_reg;
    assign out_ch.out_y_top = oyt_reg;
    assign out_ch.out_x_right = oxr_reg;
    assign out_ch.out_y_bottom = oyb_reg;
    assign out_ch.out_class = oclass_reg;
    assign out_ch.out_confidence = oconf_reg;
    assign out_ch.store_overflow = ov_reg;

    `GBN_NEVER(a_cnt_range, clk, rst_n, cnt_reg > FULL, "kept count above store size")
    `GBN_ASSERT(a_accept_area, clk, rst_n, accept |=> (state_reg == ST_AREA), "accepted beat did not start area step")
    `GBN_ASSERT(a_tok_run, clk, rst_n, t_ctl[N].valid |-> (state_reg == ST_RUN), "token left chain outside run")
    `GBN_ASSERT(a_wr_room, clk, rst_n, store_wr |=> (cnt_reg == $past(cnt_reg) + 1'b1), "store write without count step")

endmodule

[tb/sv/gbn_tb_if.sv]
// testbench side of the box channels: candidate and kept box records
// no dependencies
package gbn_tb_pkg;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic        first_of_set;
        logic [15:0] x_left;
        logic [15:0] y_top;
        logic [15:0] x_right;
        logic [15:0] y_bottom;
        logic [7:0]  class_id;
        logic [15:0] confidence;
    } cand_box_t;

    typedef struct {
        logic [15:0] x_left;
        logic [15:0] y_top;
        logic [15:0] x_right;
        logic [15:0] y_bottom;
        logic [7:0]  class_id;
        logic [15:0] confidence;
        logic        overflow;
    } kept_box_t;
endpackage

[tb/sv/tb_top.sv]
// top of the greedy box nms testbench: directed and random box streams,
// an nms predictor and a result checker; depends on greedy_box_nms_unit, gbn_pkg,
// the channel interfaces and gbn_tb_pkg
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import gbn_pkg::*;
    import gbn_tb_pkg::*;

    localparam int KEEP_DEPTH = 64;
    localparam int LATENCY    = KEEP_DEPTH + 3;
    localparam longint CYCLE_LIMIT = 1500000;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    gbn_in_if  in_ch();
    gbn_out_if out_ch();

    greedy_box_nms_unit #(.MAX_KEPT(KEEP_DEPTH), .COORD_BITS(16)) DUT (
        .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    // predictor state
    logic [15:0] kept_xl [KEEP_DEPTH];
    logic [15:0] kept_yt [KEEP_DEPTH];
    logic [15:0] kept_xr [KEEP_DEPTH];
    logic [15:0] kept_yb [KEEP_DEPTH];
    logic [31:0] kept_area [KEEP_DEPTH];
    int          kept_num;
    logic [15:0] threshold;

    kept_box_t   survivors_q[$];
    int          errors;
    longint      cycles;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_off;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    function automatic logic [15:0] span(logic [15:0] lo, logic [15:0] hi);
        return (hi > lo) ? hi - lo : 16'd0;
    endfunction

    // greedy nms against the kept set; pushes the survivor if any
    function automatic void predict_nms(cand_box_t b);
        logic [31:0] area;
        logic [31:0] inter;
        logic [32:0] total;
        logic [32:0] uni;
        logic [15:0] ix;
        logic [15:0] iy;
        logic [63:0] lhs;
        logic [63:0] rhs;
        kept_box_t   r;
        area = span(b.x_left, b.x_right) * span(b.y_top, b.y_bottom);
        if (b.first_of_set)
            kept_num = 0;
        for (int j = 0; j < kept_num; j++)
        begin
            ix = span((b.x_left > kept_xl[j]) ? b.x_left : kept_xl[j],
                      (b.x_right < kept_xr[j]) ? b.x_right : kept_xr[j]);
            iy = span((b.y_top > kept_yt[j]) ? b.y_top : kept_yt[j],
                      (b.y_bottom < kept_yb[j]) ? b.y_bottom : kept_yb[j]);
            inter = ix * iy;
            total = {1'b0, area} + {1'b0, kept_area[j]};
            uni = (total > {1'b0, inter}) ? total - inter : 33'd0;
            if (uni != 0)
            begin
                lhs = {32'd0, inter} << 16;
                rhs = {31'd0, uni} * {48'd0, threshold};
                if (lhs > rhs)
                    return;
            end
        end
        r.x_left = b.x_left;
        r.y_top = b.y_top;
        r.x_right = b.x_right;
        r.y_bottom = b.y_bottom;
        r.class_id = b.class_id;
        r.confidence = b.confidence;
        r.overflow = 1'b0;
        if (kept_num < KEEP_DEPTH)
        begin
            kept_xl[kept_num] = b.x_left;
            kept_yt[kept_num] = b.y_top;
            kept_xr[kept_num] = b.x_right;
            kept_yb[kept_num] = b.y_bottom;
            kept_area[kept_num] = area;
            kept_num++;
        end
        else
            r.overflow = 1'b1;
        survivors_q.insert(survivors_q.size(), r);
    endfunction

    task automatic send_box(cand_box_t b);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
            @(negedge clk);
        in_ch.valid <= 1'b1;
        in_ch.first_of_set <= b.first_of_set;
        in_ch.x_left <= b.x_left;
        in_ch.y_top <= b.y_top;
        in_ch.x_right <= b.x_right;
        in_ch.y_bottom <= b.y_bottom;
        in_ch.class_id <= b.class_id;
        in_ch.confidence <= b.confidence;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_nms(b);
        @(negedge clk);
        in_ch.valid <= 1'b0;
    endtask

    // receiver and checker
    initial
    begin
        kept_box_t e;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_off--;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                if (survivors_q.size() == 0)
                begin
                    $error("result beat with no expectation waiting");
                    errors++;
                end
                else
                begin
                    e = survivors_q.pop_front();
                    if (out_ch.out_x_left !== e.x_left)
                    begin
                        $error("out_x_left exp %0d got %0d", e.x_left, out_ch.out_x_left);
                        errors++;
                    end
                    if (out_ch.out_y_top !== e.y_top)
                    begin
                        $error("out_y_top exp %0d got %0d", e.y_top, out_ch.out_y_top);
                        errors++;
                    end
                    if (out_ch.out_x_right !== e.x_right)
                    begin
                        $error("out_x_right exp %0d got %0d", e.x_right, out_ch.out_x_right);
                        errors++;
                    end
                    if (out_ch.out_y_bottom !== e.y_bottom)
                    begin
                        $error("out_y_bottom exp %0d got %0d", e.y_bottom,
                               out_ch.out_y_bottom);
                        errors++;
                    end
                    if (out_ch.out_class !== e.class_id)
                    begin
                        $error("out_class exp %0d got %0d", e.class_id, out_ch.out_class);
                        errors++;
                    end
                    if (out_ch.out_confidence !== e.confidence)
                    begin
                        $error("out_confidence exp %0d got %0d", e.confidence,
                               out_ch.out_confidence);
                        errors++;
                    end
                    if (out_ch.store_overflow !== e.overflow)
                    begin
                        $error("store_overflow exp %0d got %0d", e.overflow,
                               out_ch.store_overflow);
                        errors++;
                    end
                end
            end
        end
    end

    function automatic cand_box_t make_box(logic fos, logic [15:0] xl, logic [15:0] yt,
                                           logic [15:0] xr, logic [15:0] yb);
        cand_box_t b;
        b.first_of_set = fos;
        b.x_left = xl;
        b.y_top = yt;
        b.x_right = xr;
        b.y_bottom = yb;
        b.class_id = 8'($urandom_range(255));
        b.confidence = 16'($urandom_range(65535));
        return b;
    endfunction

    // waits for all survivors, then waits out any suppressed box still in the chain
    task automatic drain();
        while (survivors_q.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    task automatic write_threshold(logic [15:0] v);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        threshold = v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic test_directed();
        cand_box_t b;
        send_box(make_box(1'b1, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF));
        send_box(make_box(1'b0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF));      // full overlap
        send_box(make_box(1'b0, 16'd100, 16'd100, 16'd50, 16'd50));      // inverted extent
        send_box(make_box(1'b0, 16'd100, 16'd100, 16'd50, 16'd50));      // zero union
        send_box(make_box(1'b1, 16'd10, 16'd10, 16'd20, 16'd20));
        send_box(make_box(1'b0, 16'd20, 16'd20, 16'd30, 16'd30));        // touching corner
        send_box(make_box(1'b0, 16'd12, 16'd10, 16'd22, 16'd20));        // iou 2/3
        send_box(make_box(1'b0, 16'd15, 16'd10, 16'd25, 16'd20));        // iou exactly 1/3
        b = make_box(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        b.class_id = 8'hFF;
        b.confidence = 16'hFFFF;
        send_box(b);
        b = make_box(1'b0, 16'd0, 16'd0, 16'd0, 16'd0);
        b.class_id = 8'd0;
        b.confidence = 16'd0;
        send_box(b);
        write_threshold(16'd0);
        send_box(make_box(1'b1, 16'd0, 16'd0, 16'd100, 16'd100));
        send_box(make_box(1'b0, 16'd99, 16'd99, 16'd200, 16'd200));      // tiny overlap
        send_box(make_box(1'b0, 16'd300, 16'd300, 16'd400, 16'd400));
        write_threshold(16'hFFFF);
        send_box(make_box(1'b1, 16'd0, 16'd0, 16'd100, 16'd100));
        send_box(make_box(1'b0, 16'd0, 16'd0, 16'd100, 16'd100));        // identical
        send_box(make_box(1'b0, 16'd0, 16'd0, 16'd100, 16'd99));
    endtask

    // overflow: fill the store with disjoint boxes and keep going
    task automatic test_store_full();
        write_threshold(16'd32768);
        for (int i = 0; i < KEEP_DEPTH + 6; i++)
            send_box(make_box(i == 0, 16'(i * 600), 16'd0, 16'(i * 600 + 500), 16'd500));
    endtask

    function automatic cand_box_t rand_box(logic fos, int max_span);
        cand_box_t b;
        logic [15:0] xl;
        logic [15:0] yt;
        xl = 16'($urandom_range(65535));
        yt = 16'($urandom_range(65535));
        b = make_box(fos, xl, yt, 16'(xl + $urandom_range(max_span)),
                     16'(yt + $urandom_range(max_span)));
        return b;
    endfunction

    task automatic test_random(int count);
        cand_box_t b;
        int left;
        int set_len;
        logic [15:0] cx;
        logic [15:0] cy;
        left = count;
        while (left > 0)
        begin
            set_len = $urandom_range(30, 1);
            cx = 16'($urandom_range(65535));
            cy = 16'($urandom_range(65535));
            for (int i = 0; i < set_len && left > 0; i++)
            begin
                case ($urandom_range(9))
                    0: b = make_box(1'b0, 16'($urandom_range(65535)),
                                    16'($urandom_range(65535)),
                                    16'($urandom_range(65535)),
                                    16'($urandom_range(65535)));
                    1: b = rand_box(1'b0, 65535);
                    default:
                    begin
                        // clustered boxes around one centre so that they overlap
                        b = make_box(1'b0, 16'(cx + $urandom_range(400)),
                                     16'(cy + $urandom_range(400)),
                                     16'(cx + 300 + $urandom_range(700)),
                                     16'(cy + 300 + $urandom_range(700)));
                    end
                endcase
                b.first_of_set = (i == 0) ? 1'b1 : ($urandom_range(49) == 0);
                send_box(b);
                left--;
            end
        end
    endtask

    // receiver holds off while boxes keep coming, filling the pipeline
    task automatic test_back_pressure();
        cand_box_t b;
        hold_off = 800;
        for (int i = 0; i < 12; i++)
        begin
            b = rand_box(i == 0, 4000);
            send_box(b);
        end
    endtask

    initial
    begin
        errors = 0;
        hold_off = 0;
        kept_num = 0;
        threshold = THR_RESET;
        send_idle_pct = 38;
        recv_idle_pct = 46;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 16'd0;
        in_ch.valid = 1'b0;
        in_ch.first_of_set = 1'b0;
        in_ch.x_left = 16'd0;
        in_ch.y_top = 16'd0;
        in_ch.x_right = 16'd0;
        in_ch.y_bottom = 16'd0;
        in_ch.class_id = 8'd0;
        in_ch.confidence = 16'd0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_store_full();
        test_back_pressure();
        write_threshold(16'd20000);
        test_random(500);
        send_idle_pct = 46;
        recv_idle_pct = 38;
        write_threshold(16'd45000);
        test_random(500);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_threshold(16'd1);
        test_random(250);
        write_threshold(16'd65534);
        test_random(250);

        drain();
        if (errors == 0 && survivors_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
